/* design/strle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strle_pkg
// Types and constants shared by the seven-bit text run-length entry unpacker.
// ----------------------------------------------------------------------------
package strle_pkg;

    localparam int unsigned SYM_W       = 8;
    localparam int unsigned GROUP_W     = 7;
    localparam int unsigned RUN_W       = 6;   // a run carries up to 47 groups
    localparam int unsigned ENTRY_W     = 8;
    localparam int unsigned NUM_ENTRIES = 7;
    localparam int unsigned BPE_W       = 4;
    localparam int unsigned TOTAL_W     = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned BUF_W       = 15;
    localparam int unsigned BCNT_W      = 4;

    localparam logic [SYM_W-1:0] SYM_NUL      = 8'h00;
    localparam logic [SYM_W-1:0] SYM_HIGH_LO  = 8'hA0;
    localparam logic [SYM_W-1:0] SYM_RUN_LO   = 8'hD1;
    localparam logic [SYM_W-1:0] OFFSET_LOW   = 8'h20;
    localparam logic [SYM_W-1:0] OFFSET_HIGH  = 8'h51;

    localparam logic [BPE_W-1:0]   BPE_RESET   = 4'd8;
    localparam logic [BPE_W-1:0]   BPE_MAX     = 4'd8;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd0;

    localparam logic CFG_IDX_BPE   = 1'b0;
    localparam logic CFG_IDX_TOTAL = 1'b1;

    typedef enum logic [1:0] {
        CMD_GROUP = 2'd0,
        CMD_ZERO  = 2'd1,
        CMD_END   = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_TRUNC   = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic                 line_start;
        logic [GROUP_W-1:0]   group;
        logic [RUN_W-1:0]     runs;
    } cmd_t;

    typedef struct packed {
        logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] entries;
        logic [2:0]                          count;
        status_t                             status;
        logic                                finished;
        logic                                last;
    } res_t;

endpackage

/* design/seven_bit_text_rle_entry_unpacker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_bit_text_rle_entry_unpacker_top
// Turns seven-bit text characters into fixed-width entries, one result per
// seven-bit group, with run characters expanding into zero groups.
// ----------------------------------------------------------------------------
// An item passes through the command queue into the back end, whose result is
// held in an output register. Throughput: one group per cycle through the
// single extraction stage while the output is free and no stop is held; a
// run character of length k yields k groups. A two-entry command queue lets
// input continue while results wait. Reset clears the bit buffer, entry count
// and queues; registers return to width 8 and total 0.
module seven_bit_text_rle_entry_unpacker_top #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [strle_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          symbol,
    input  logic                                line_start,
    input  logic                                end_of_data,
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          entry_a,
    output logic [7:0]                          entry_b,
    output logic [7:0]                          entry_c,
    output logic [7:0]                          entry_d,
    output logic [7:0]                          entry_e,
    output logic [7:0]                          entry_f,
    output logic [7:0]                          entry_g,
    output logic [2:0]                          entry_count,
    output logic [1:0]                          status,
    output logic                                finished,
    output logic                                last
);
    import strle_pkg::*;

    logic [BPE_W-1:0]   bpe_reg;
    logic [TOTAL_W-1:0] total_reg;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic head_valid;
    logic head_pop;
    logic res_valid;
    res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpe_reg   <= BPE_RESET;
            total_reg <= TOTAL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_IDX_BPE:   bpe_reg   <= cfg_wdata[BPE_W-1:0];
                CFG_IDX_TOTAL: total_reg <= cfg_wdata[TOTAL_W-1:0];
                default:       bpe_reg   <= bpe_reg;
            endcase
        end
    end

    strle_front u_front (
        .symbol      (symbol),
        .line_start  (line_start),
        .end_of_data (end_of_data),
        .cmd         (front_cmd)
    );

    strle_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (front_cmd),
        .full     (full),
        .rd_en    (head_pop),
        .rd_valid (head_valid),
        .rd_data  (head_cmd)
    );

    strle_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .bits_per_entry (bpe_reg),
        .entry_total    (total_reg),
        .cmd_valid      (head_valid),
        .cmd            (head_cmd),
        .cmd_pop        (head_pop),
        .res_valid      (res_valid),
        .res            (res),
        .res_pop        (pop)
    );

    assign empty       = !res_valid;
    assign entry_a     = res.entries[0];
    assign entry_b     = res.entries[1];
    assign entry_c     = res.entries[2];
    assign entry_d     = res.entries[3];
    assign entry_e     = res.entries[4];
    assign entry_f     = res.entries[5];
    assign entry_g     = res.entries[6];
    assign entry_count = res.count;
    assign status      = res.status;
    assign finished    = res.finished;
    assign last        = res.last;

    // an error or completion always closes the item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != STATUS_OK || finished)) |-> last)
        else $error("error or finished result not marked last");

    a_status_no_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != STATUS_OK) |-> (entry_count == 3'd0 && !finished))
        else $error("error result carries entries or finished");

    a_queue_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> head_valid)
        else $error("command queue full but head not valid");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res)))
        else $error("waiting result changed before it was taken");

endmodule

/* design/strle_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strle_front
// Classifies each text character into a group command for the back end.
// ----------------------------------------------------------------------------
module strle_front (
    input  logic [7:0]     symbol,
    input  logic           line_start,
    input  logic           end_of_data,
    output strle_pkg::cmd_t cmd
);
    import strle_pkg::*;

    logic [SYM_W-1:0] run_len;
    logic [SYM_W-1:0] hi_grp;
    logic [SYM_W-1:0] lo_grp;

    assign run_len = symbol - SYM_RUN_LO + 8'd1;
    assign hi_grp  = symbol - OFFSET_HIGH;
    assign lo_grp  = symbol - OFFSET_LOW;

    always_comb
    begin
        cmd.kind       = CMD_GROUP;
        cmd.line_start = line_start;
        cmd.group      = '0;
        cmd.runs       = RUN_W'(1);
        priority if (end_of_data)
        begin
            cmd.kind = CMD_END;
        end
        else if (symbol == SYM_NUL)
        begin
            cmd.kind = CMD_ZERO;
        end
        else if (symbol >= SYM_RUN_LO)
        begin
            cmd.runs = run_len[RUN_W-1:0];
        end
        else if (symbol >= SYM_HIGH_LO)
        begin
            cmd.group = hi_grp[GROUP_W-1:0];
        end
        else
        begin
            // low characters drop the space offset and keep the low seven bits, so codes below it wrap
            cmd.group = lo_grp[GROUP_W-1:0];
        end
    end

endmodule

/* design/strle_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strle_fifo
// Two-entry command queue between the classifier and the unpacking engine.
// ----------------------------------------------------------------------------
module strle_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  strle_pkg::cmd_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output strle_pkg::cmd_t rd_data
);
    import strle_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_wr;
    logic       do_rd;

    assign full     = (fill_reg == 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* design/strle_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strle_back
// Unpacking engine: while the output is free and not stopped, shifts one group
// a cycle into the buffer, registers the entries it completes as the result.
// ----------------------------------------------------------------------------
module strle_back #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [strle_pkg::BPE_W-1:0]            bits_per_entry,
    input  logic [strle_pkg::TOTAL_W-1:0]          entry_total,
    input  logic                                   cmd_valid,
    input  strle_pkg::cmd_t                        cmd,
    output logic                                   cmd_pop,
    output logic                                   res_valid,
    output strle_pkg::res_t                        res,
    input  logic                                   res_pop
);
    import strle_pkg::*;

    localparam int unsigned CMP_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

    logic [BUF_W-1:0]       bit_buffer_reg;
    logic [BUF_W-1:0]       bit_buffer_next;
    logic [BCNT_W-1:0]      bit_count_reg;
    logic [BCNT_W-1:0]      bit_count_next;
    logic [COUNT_WIDTH-1:0] done_reg;
    logic [COUNT_WIDTH-1:0] done_next;
    logic                   stopped_reg;
    logic                   stopped_next;
    logic [RUN_W-1:0]       run_idx_reg;
    logic [RUN_W-1:0]       run_idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    res_t                   out_reg;
    res_t                   out_next;

    logic                   out_free;
    logic                   step;
    logic [BCNT_W-1:0]      cnt0;
    logic [BPE_W-1:0]       w;
    logic [CMP_W-1:0]       done_ext;
    logic [CMP_W-1:0]       done_new_ext;
    logic [CMP_W-1:0]       total_ext;
    logic [CMP_W-1:0]       rem;
    logic                   all_done0;
    logic [BUF_W-1:0]       buf_new;
    logic [4:0]             cnt_g;
    logic [ENTRY_W-1:0]     mask;
    logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] ents;
    logic [2:0]             n;
    logic [5:0]             n_w;
    logic [5:0]             cnt_left;
    logic [COUNT_WIDTH-1:0] done_new;
    logic                   fin;
    logic                   run_end;

    assign out_free  = !out_valid_reg || res_pop;
    assign step      = cmd_valid && !stopped_reg && out_free;
    assign cmd_pop   = cmd_valid && (stopped_reg || (step && (cmd.kind != CMD_GROUP || run_end)));
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        priority if (bits_per_entry == '0)
        begin
            w = BPE_W'(1);
        end
        else if (bits_per_entry > BPE_MAX)
        begin
            w = BPE_MAX;
        end
        else
        begin
            w = bits_per_entry;
        end
    end

    // line start drops the buffered bits before the first group of the item
    assign cnt0      = (run_idx_reg == '0 && cmd.line_start) ? '0 : bit_count_reg;
    assign done_ext  = CMP_W'(done_reg);
    assign total_ext = CMP_W'(entry_total);
    assign all_done0 = done_ext >= total_ext;
    assign rem       = total_ext - done_ext;
    assign buf_new   = {bit_buffer_reg[BUF_W-GROUP_W-1:0], cmd.group};
    assign cnt_g     = {1'b0, cnt0} + 5'd7;
    assign mask      = ENTRY_W'((9'd1 << w) - 9'd1);

    // each entry is taken straight from the buffer at its own offset
    always_comb
    begin
        logic [5:0]       need;
        logic [4:0]       sh;
        logic [BUF_W-1:0] shifted;
        n    = '0;
        ents = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            need    = 6'(i + 1) * {2'b00, w};
            sh      = cnt_g - need[4:0];
            shifted = buf_new >> sh;
            if (need <= {1'b0, cnt_g} && rem > CMP_W'(i) && !all_done0)
            begin
                ents[i] = shifted[ENTRY_W-1:0] & mask;
                n       = 3'(i + 1);
            end
        end
    end

    assign n_w          = 6'(n) * {2'b00, w};
    assign cnt_left     = {1'b0, cnt_g} - n_w;
    assign done_new     = done_reg + COUNT_WIDTH'(n);
    assign done_new_ext = CMP_W'(done_new);
    assign fin          = done_new_ext >= total_ext;
    assign run_end      = fin || (run_idx_reg + RUN_W'(1) == cmd.runs);

    always_comb
    begin
        bit_buffer_next = bit_buffer_reg;
        bit_count_next  = bit_count_reg;
        done_next       = done_reg;
        stopped_next    = stopped_reg;
        run_idx_next    = run_idx_reg;
        out_valid_next  = out_valid_reg && !res_pop;
        out_next        = out_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            out_next.last  = 1'b1;
            unique case (cmd.kind)
                CMD_END:
                begin
                    out_next.finished = all_done0;
                    out_next.status   = all_done0 ? STATUS_OK : STATUS_TRUNC;
                    stopped_next      = 1'b1;
                end
                CMD_ZERO:
                begin
                    out_next.finished = all_done0;
                    out_next.status   = all_done0 ? STATUS_OK : STATUS_INVALID;
                    stopped_next      = 1'b1;
                end
                CMD_GROUP:
                begin
                    out_next.entries  = ents;
                    out_next.count    = n;
                    out_next.finished = fin;
                    out_next.last     = run_end;
                    bit_buffer_next   = buf_new;
                    bit_count_next    = cnt_left[BCNT_W-1:0];
                    done_next         = done_new;
                    stopped_next      = fin;
                    run_idx_next      = run_end ? '0 : run_idx_reg + RUN_W'(1);
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !res_pop;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            done_reg       <= '0;
            stopped_reg    <= 1'b0;
            run_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bit_buffer_reg <= bit_buffer_next;
            bit_count_reg  <= bit_count_next;
            done_reg       <= done_next;
            stopped_reg    <= stopped_next;
            run_idx_reg    <= run_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seven-bit text run-length entry unpacker. Text
// characters go in through the push/full side, a local model predicts the
// unpacked entry groups, and every popped result is compared with the oldest
// prediction. Widths and totals are reprogrammed between drained phases, and
// the stream is finally closed by one of its possible stop conditions.
// ----------------------------------------------------------------------------
module tb_top;
    import strle_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int PHASE_ITEMS   = 22;

    typedef enum int {
        STOP_DATA_DONE,
        STOP_TRUNCATED,
        STOP_BAD_SYMBOL,
        STOP_NOTHING_LEFT,
        STOP_COUNT_REACHED
    } stop_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic                  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  push;
    logic                  full;
    logic [7:0]            symbol;
    logic                  line_start;
    logic                  end_of_data;
    logic                  empty;
    logic                  pop;
    logic [7:0]            entry_a;
    logic [7:0]            entry_b;
    logic [7:0]            entry_c;
    logic [7:0]            entry_d;
    logic [7:0]            entry_e;
    logic [7:0]            entry_f;
    logic [7:0]            entry_g;
    logic [2:0]            entry_count;
    logic [1:0]            status;
    logic                  finished;
    logic                  last;

    // unpacker model state
    logic [BUF_W-1:0]      bit_store;
    int                    bits_held;
    logic [TOTAL_W-1:0]    entries_taken;
    bit                    halted;
    logic [BPE_W-1:0]      cfg_width;
    logic [TOTAL_W-1:0]    cfg_total;

    res_t                  unpacked_q[$];
    int                    error_count;
    int                    idle_cycles;
    bit                    tx_idle_on;
    bit                    rx_idle_on;
    bit                    rx_hold;
    int                    rx_wait;

    seven_bit_text_rle_entry_unpacker_top u_top (.*);

    always #1 clk = ~clk;

    function automatic bit total_reached();
        return entries_taken >= cfg_total;
    endfunction

    // one 7-bit group into the buffer, then take entries MSB first
    function automatic res_t shift_group(input logic [GROUP_W-1:0] grp);
        res_t r;
        int   w;
        int   n;
        r = '0;
        w = (cfg_width == 0) ? 1 : ((cfg_width > BPE_MAX) ? BPE_MAX : cfg_width);
        bit_store = {bit_store[BUF_W-GROUP_W-1:0], grp};
        bits_held = bits_held + GROUP_W;
        n = 0;
        while (n < NUM_ENTRIES && bits_held >= w && !total_reached()) begin
            r.entries[n] = 8'((bit_store >> (bits_held - w)) & ((1 << w) - 1));
            bits_held = bits_held - w;
            entries_taken = entries_taken + 1'b1;
            n++;
        end
        r.count = 3'(n);
        r.finished = total_reached();
        return r;
    endfunction

    function automatic void unpack_symbol(input logic [7:0] sym, input logic ls,
                                          input logic eod);
        res_t             r;
        logic [GROUP_W-1:0] grp;
        int               runs;
        int               k;
        if (halted)
            return;
        r = '0;
        r.last = 1'b1;
        if (eod) begin
            if (total_reached())
                r.finished = 1'b1;
            else
                r.status = STATUS_TRUNC;
            halted = 1'b1;
            unpacked_q.push_back(r);
            return;
        end
        if (ls)
            bits_held = 0;
        if (total_reached()) begin
            r.finished = 1'b1;
            halted = 1'b1;
            unpacked_q.push_back(r);
            return;
        end
        if (sym == SYM_NUL) begin
            r.status = STATUS_INVALID;
            halted = 1'b1;
            unpacked_q.push_back(r);
            return;
        end
        if (sym >= SYM_RUN_LO) begin
            runs = sym - SYM_RUN_LO + 1;
            grp = '0;
        end else if (sym >= SYM_HIGH_LO) begin
            runs = 1;
            grp = GROUP_W'(sym - OFFSET_HIGH);
        end else begin
            runs = 1;
            grp = GROUP_W'(sym - OFFSET_LOW);   // wraps below the space character
        end
        for (k = 0; k < runs; k++) begin
            r = shift_group(grp);
            if (r.finished)
                halted = 1'b1;
            r.last = (k == runs - 1) || halted;
            unpacked_q.push_back(r);
            if (halted)
                break;
        end
    endfunction

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] random_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(8'h20, 8'h9F));
        if (r < 60)
            return 8'($urandom_range(SYM_HIGH_LO, SYM_RUN_LO - 1));
        if (r < 72)
            return 8'($urandom_range(SYM_RUN_LO, SYM_RUN_LO + 7));
        if (r < 77)
            return 8'($urandom_range(SYM_RUN_LO + 8, 8'hFF));
        if (r < 87)
            return 8'($urandom_range(1, OFFSET_LOW - 1));
        return 8'($urandom_range(1, 8'hFF));
    endfunction

    // upper bits of the width word are don't-care for the block
    function automatic logic [CFG_DATA_W-1:0] width_word(input logic [BPE_W-1:0] w);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[BPE_W-1:0] = w;
        return word;
    endfunction

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    task automatic wait_drained();
        do
            @(posedge clk);
        while (unpacked_q.size() != 0);
    endtask

    task automatic send_item(input logic [7:0] sym, input logic ls, input logic eod);
        int gap;
        push        <= 1'b1;
        symbol      <= sym;
        line_start  <= ls;
        end_of_data <= eod;
        do
            @(negedge clk);
        while (full);
        @(posedge clk);
        unpack_symbol(sym, ls, eod);
        gap = pick_gap(tx_idle_on);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] word);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= word;
        @(posedge clk);
        if (idx == CFG_IDX_BPE)
            cfg_width = word[BPE_W-1:0];
        else
            cfg_total = word[TOTAL_W-1:0];
    endtask

    // registers only change once the block has gone quiet
    task automatic program_unpacker(input bit wr_width, input logic [BPE_W-1:0] w,
                                    input bit wr_total, input logic [TOTAL_W-1:0] total);
        push <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (wr_width)
            write_reg(CFG_IDX_BPE, width_word(w));
        if (wr_total)
            write_reg(CFG_IDX_TOTAL, total);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_symbol_classes();
        logic [7:0] syms[11];
        syms = '{8'h20, 8'h9F, 8'h01, 8'h1F, 8'h70, 8'h7F, 8'hA0, 8'hD0, 8'hD1, 8'hFF,
                 8'h55};
        // width 7 makes each entry equal to its group
        program_unpacker(1'b1, 4'd7, 1'b1, 16'hFFFF);
        foreach (syms[i])
            send_item(syms[i], i == 10, 1'b0);
    endtask

    task automatic test_entry_widths();
        program_unpacker(1'b1, 4'd0, 1'b0, '0);
        send_item(8'h7E, 1'b0, 1'b0);
        program_unpacker(1'b1, 4'd15, 1'b0, '0);
        send_item(8'h41, 1'b1, 1'b0);     // seven bits held, nothing taken yet
        send_item(8'h42, 1'b0, 1'b0);
        // narrowing leaves more bits than seven entries can use
        program_unpacker(1'b1, 4'd1, 1'b0, '0);
        send_item(8'h43, 1'b0, 1'b0);
        send_item(8'hB7, 1'b0, 1'b0);
        program_unpacker(1'b1, 4'd8, 1'b0, '0);
        send_item(8'hC3, 1'b1, 1'b0);
        program_unpacker(1'b1, 4'd4, 1'b0, '0);
        send_item(8'h9A, 1'b0, 1'b0);
        send_item(8'hE0, 1'b1, 1'b0);
    endtask

    task automatic test_backpressure();
        int n;
        program_unpacker(1'b1, 4'($urandom_range(1, 8)), 1'b1, 16'hFFFF);
        tx_idle_on = 1'b0;
        rx_hold <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        // keep offering until the hold is released and input has stalled
        for (n = 0; n < 40 && (n == 0 || rx_hold); n++)
            send_item(random_symbol(), $urandom_range(0, 99) < 12, 1'b0);
        push <= 1'b0;
        wait_drained();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_stream();
        logic [BPE_W-1:0] plan[5];
        int               phase;
        plan = '{4'd3, 4'd0, 4'd15, 4'd1, 4'd8};
        for (phase = 0; phase < 5; phase++) begin
            program_unpacker(1'b1, (phase == 4) ? 4'($urandom) : plan[phase], 1'b1,
                             phase[0] ? 16'($urandom_range(16'hF000, 16'hFFFE)) : 16'hFFFF);
            tx_idle_on = (phase != 2) && (phase != 4);
            rx_idle_on = (phase != 3) && (phase != 4);
            repeat (PHASE_ITEMS)
                send_item(random_symbol(), $urandom_range(0, 99) < 12, 1'b0);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_stream_end();
        stop_kind_t kind;
        int         n;
        kind = stop_kind_t'($urandom_range(STOP_DATA_DONE, STOP_COUNT_REACHED));
        case (kind)
            STOP_DATA_DONE: begin
                program_unpacker(1'b0, '0, 1'b1, entries_taken);
                send_item(8'($urandom), 1'($urandom), 1'b1);
            end
            STOP_TRUNCATED, STOP_BAD_SYMBOL: begin
                program_unpacker(1'b1, 4'($urandom), 1'b1, 16'hFFFF);
                repeat ($urandom_range(1, 5))
                    send_item(random_symbol(), 1'($urandom), 1'b0);
                if (kind == STOP_TRUNCATED)
                    send_item(8'($urandom), 1'($urandom), 1'b1);
                else
                    send_item(SYM_NUL, 1'($urandom), 1'b0);
            end
            STOP_NOTHING_LEFT: begin
                program_unpacker(1'b0, '0, 1'b1, $urandom_range(0, 1) ? '0 : entries_taken);
                send_item(8'($urandom), 1'($urandom), 1'b0);
            end
            default: begin
                // total lands 1 to 40 entries on; a run that crosses it has its tail dropped
                program_unpacker(1'b1, 4'($urandom_range(1, 8)), 1'b1,
                                 entries_taken + 16'($urandom_range(1, 40)));
                for (n = 0; n < 60 && !halted; n++)
                    send_item($urandom_range(0, 1) ? 8'($urandom_range(SYM_RUN_LO, 8'hFF))
                                                   : random_symbol(),
                              $urandom_range(0, 99) < 10, 1'b0);
            end
        endcase
    endtask

    // once stopped, nothing but reset brings the block back
    task automatic test_after_stop();
        program_unpacker(1'b1, 4'($urandom), 1'b1, '0);
        repeat (4)
            send_item(8'($urandom), 1'($urandom), 1'($urandom));
        send_item(SYM_NUL, 1'b1, 1'b1);
        program_unpacker(1'b0, '0, 1'b1, 16'hFFFF);
        repeat (3)
            send_item(random_symbol(), 1'($urandom), 1'b0);
    endtask

    initial begin : result_checker
        res_t seen;
        res_t want;
        pop = 1'b0;
        rx_wait = 0;
        forever begin
            @(posedge clk);
            if (rx_hold) begin
                pop <= 1'b0;
            end else if (rx_wait > 0) begin
                pop <= 1'b0;
                rx_wait--;
            end else begin
                pop <= 1'b1;
                rx_wait = pick_gap(rx_idle_on);
            end
            @(negedge clk);
            if (rst_n && pop && !empty) begin
                seen.entries  = {entry_g, entry_f, entry_e, entry_d, entry_c, entry_b, entry_a};
                seen.count    = entry_count;
                seen.status   = status_t'(status);
                seen.finished = finished;
                seen.last     = last;
                if (unpacked_q.size() == 0) begin
                    report_error($sformatf("%0t: result with nothing expected: entries %h count %0d status %0d fin %b last %b",
                                           $realtime, seen.entries, seen.count, seen.status,
                                           seen.finished, seen.last));
                end else begin
                    want = unpacked_q.pop_front();
                    if (seen.entries !== want.entries || seen.count !== want.count ||
                        seen.status !== want.status || seen.finished !== want.finished ||
                        seen.last !== want.last)
                        report_error($sformatf({"%0t: got entries %h count %0d status %0d fin %b last %b,",
                                                " exp entries %h count %0d status %0d fin %b last %b"},
                                               $realtime, seen.entries, seen.count, seen.status,
                                               seen.finished, seen.last, want.entries, want.count,
                                               want.status, want.finished, want.last));
                end
            end
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(negedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_IDX_BPE;
        cfg_wdata     = '0;
        push          = 1'b0;
        symbol        = '0;
        line_start    = 1'b0;
        end_of_data   = 1'b0;
        rx_hold       = 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        error_count   = 0;
        bit_store     = '0;
        bits_held     = 0;
        entries_taken = '0;
        halted        = 1'b0;
        cfg_width     = BPE_RESET;
        cfg_total     = TOTAL_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_symbol_classes();
        test_entry_widths();
        test_backpressure();
        test_random_stream();
        test_stream_end();
        test_after_stop();

        push <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
